// ===== rtl/pbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpc_pkg: shared types and constants for the point box and polygon crop
// Holds the register and action codes, the state type, the handshake
// structs between the modules and the reset values of bounds and vertices.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpc_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_COORD_BITS   = 24;
    localparam int NUM_REGS         = 8;
    localparam int REG_IDX_W        = 3;
    localparam int TARG_W           = 5;
    localparam int INTEN_W          = 16;
    localparam int POLY_SIZE_RST    = 4;
    localparam int MIN_POLY         = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BOX_X_MIN  = 3'd0,
        REG_BOX_X_MAX  = 3'd1,
        REG_BOX_Y_MIN  = 3'd2,
        REG_BOX_Y_MAX  = 3'd3,
        REG_BOX_Z_MIN  = 3'd4,
        REG_BOX_Z_MAX  = 3'd5,
        REG_BAND_Z_MIN = 3'd6,
        REG_BAND_Z_MAX = 3'd7
    } pbpc_reg_t;

    typedef enum logic [1:0] {
        ACT_POINT  = 2'd0,
        ACT_VERTEX = 2'd1,
        ACT_SIZE   = 2'd2
    } pbpc_action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } pbpc_state_t;

    // Token that walks down the edge cells with the running crossing parity.
    typedef struct packed {
        logic valid;
        logic parity;
    } pbpc_token_t;

    // Outcome of the bound checks for the point at the input.
    typedef struct packed {
        logic box_ok;
        logic band_ok;
    } pbpc_chk_t;

    function automatic int bound_rst(input int idx);
        int v;
        v = 0;
        unique case (idx)
            0:       v = -20000;
            1:       v = 50000;
            2:       v = -30000;
            3:       v = 30000;
            4:       v = -3000;
            5:       v = 3000;
            6:       v = -10000;
            7:       v = 10000;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic int vtx_x_rst(input int idx);
        int v;
        v = 0;
        unique case (idx)
            0:       v = 53;
            1:       v = 66;
            2:       v = -4925;
            3:       v = -4947;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic int vtx_y_rst(input int idx);
        int v;
        v = 0;
        unique case (idx)
            0:       v = -1318;
            1:       v = 1330;
            2:       v = 1310;
            3:       v = -1040;
            default: v = 0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pbpc_edge_cell.sv =====
// ----------------------------------------------------------------------------
// pbpc_edge_cell: one polygon vertex and the crossing test of its edge
// Stores vertex IDX and tests the edge to the next vertex (or back to
// vertex 0 when this is the last active vertex) against the current point.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpc_edge_cell #(
    parameter int IDX          = 0,
    parameter int MAX_VERTICES = pbpc_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pbpc_pkg::DEF_COORD_BITS,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                vtx_we,
    input  logic [pbpc_pkg::TARG_W-1:0]         vtx_slot,
    input  logic signed [COORD_BITS-1:0]        wr_x,
    input  logic signed [COORD_BITS-1:0]        wr_y,
    input  logic signed [COORD_BITS-1:0]        pt_x,
    input  logic signed [COORD_BITS-1:0]        pt_y,
    input  logic signed [COORD_BITS-1:0]        v0_x,
    input  logic signed [COORD_BITS-1:0]        v0_y,
    input  logic signed [COORD_BITS-1:0]        nxt_x,
    input  logic signed [COORD_BITS-1:0]        nxt_y,
    input  logic [CNT_W-1:0]                    poly_n,
    input  pbpc_pkg::pbpc_token_t               tok_in,
    output pbpc_pkg::pbpc_token_t               tok_out,
    output logic signed [COORD_BITS-1:0]        vx,
    output logic signed [COORD_BITS-1:0]        vy
);
    import pbpc_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam logic signed [COORD_BITS-1:0] RST_X = COORD_BITS'(vtx_x_rst(IDX));
    localparam logic signed [COORD_BITS-1:0] RST_Y = COORD_BITS'(vtx_y_rst(IDX));

    logic signed [COORD_BITS-1:0] vx_reg;
    logic signed [COORD_BITS-1:0] vy_reg;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic                         active;
    logic                         last;
    logic signed [EW-1:0]         dx;
    logic signed [EW-1:0]         dy;
    logic signed [EW-1:0]         ex;
    logic signed [EW-1:0]         ey;
    logic signed [PW-1:0]         lhs;
    logic signed [PW-1:0]         rhs;
    pbpc_token_t                  s1_tok_reg;
    logic                         s1_cross_reg;
    logic                         s1_dpos_reg;
    logic signed [PW-1:0]         s1_lhs_reg;
    logic signed [PW-1:0]         s1_rhs_reg;
    logic                         hit;
    pbpc_token_t                  tok_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= RST_X;
            vy_reg <= RST_Y;
        end
        else if (vtx_we && (32'(vtx_slot) == IDX))
        begin
            vx_reg <= wr_x;
            vy_reg <= wr_y;
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;

    // The closing edge runs from the last active vertex back to vertex 0.
    assign active = 32'(poly_n) > IDX;
    assign last   = 32'(poly_n) == (IDX + 1);
    assign bx     = last ? v0_x : nxt_x;
    assign by     = last ? v0_y : nxt_y;

    // x < ax + (bx-ax)*(y-ay)/(by-ay), cross-multiplied with the sign of by-ay.
    assign dx  = EW'(pt_x) - EW'(vx_reg);
    assign dy  = EW'(by) - EW'(vy_reg);
    assign ex  = EW'(bx) - EW'(vx_reg);
    assign ey  = EW'(pt_y) - EW'(vy_reg);
    assign lhs = dx * dy;
    assign rhs = ex * ey;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
        end
        else
        begin
            s1_tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cross_reg <= active && ((vy_reg > pt_y) != (by > pt_y));
        s1_dpos_reg  <= dy > EW'(0);
        s1_lhs_reg   <= lhs;
        s1_rhs_reg   <= rhs;
    end

    assign hit = s1_cross_reg &&
                 (s1_dpos_reg ? (s1_lhs_reg < s1_rhs_reg) : (s1_rhs_reg < s1_lhs_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_reg <= '0;
        end
        else
        begin
            tok_out_reg.valid  <= s1_tok_reg.valid;
            tok_out_reg.parity <= s1_tok_reg.parity ^ hit;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

`default_nettype wire

// ===== rtl/pbpc_bounds.sv =====
// ----------------------------------------------------------------------------
// pbpc_bounds: bound registers and the box and band checks
// Holds the eight inclusive bounds written over the configuration channel
// and compares the incoming point against the box and the height band.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpc_bounds #(
    parameter int COORD_BITS = pbpc_pkg::DEF_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbpc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    input  logic signed [COORD_BITS-1:0]        pt_x,
    input  logic signed [COORD_BITS-1:0]        pt_y,
    input  logic signed [COORD_BITS-1:0]        pt_z,
    output pbpc_pkg::pbpc_chk_t                 chk
);
    import pbpc_pkg::*;

    logic signed [COORD_BITS-1:0] bound_reg [NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                bound_reg[k] <= COORD_BITS'(bound_rst(k));
            end
        end
        else if (cfg_valid)
        begin
            bound_reg[cfg_index] <= cfg_data;
        end
    end

    assign chk.box_ok = (pt_x >= bound_reg[REG_BOX_X_MIN]) && (pt_x <= bound_reg[REG_BOX_X_MAX])
                     && (pt_y >= bound_reg[REG_BOX_Y_MIN]) && (pt_y <= bound_reg[REG_BOX_Y_MAX])
                     && (pt_z >= bound_reg[REG_BOX_Z_MIN]) && (pt_z <= bound_reg[REG_BOX_Z_MAX]);

    assign chk.band_ok = (pt_z >= bound_reg[REG_BAND_Z_MIN]) && (pt_z <= bound_reg[REG_BAND_Z_MAX]);

endmodule

`default_nettype wire

// ===== rtl/point_box_and_polygon_crop.sv =====
// ----------------------------------------------------------------------------
// point_box_and_polygon_crop: lidar point crop with footprint removal
// Drops non-finite points and points outside the XYZ box, and points in the
// height band whose XY falls inside the vehicle footprint polygon.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ----------------------------------------
//  in        in_valid / in_ready    action, pos_x/y/z, intensity, finite,
//                                   table_arg
//  out       out_valid / out_ready  kept_x/y/z, kept_intensity
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Table writes, and points that fail the finite or box check, finish at the transfer.
// A point that passes the box but skips the polygon test goes to the done state.
// A point that needs the polygon test waits in the walk state while its
// parity token walks the chain of edge cells, two register stages per cell.
// Reset is asynchronous and active low; it restores the default bounds,
// the default four-vertex footprint and a polygon size of four.
// A stalled output holds its result; the next item is still taken meanwhile,
// and only a further kept point waits until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module point_box_and_polygon_crop #(
    parameter int MAX_VERTICES = pbpc_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pbpc_pkg::DEF_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          action,
    input  logic signed [COORD_BITS-1:0]        pos_x,
    input  logic signed [COORD_BITS-1:0]        pos_y,
    input  logic signed [COORD_BITS-1:0]        pos_z,
    input  logic [pbpc_pkg::INTEN_W-1:0]        intensity,
    input  logic                                finite,
    input  logic [pbpc_pkg::TARG_W-1:0]         table_arg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        kept_x,
    output logic signed [COORD_BITS-1:0]        kept_y,
    output logic signed [COORD_BITS-1:0]        kept_z,
    output logic [pbpc_pkg::INTEN_W-1:0]        kept_intensity,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbpc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data
);
    import pbpc_pkg::*;

    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int SIZE_RST = (POLY_SIZE_RST > MAX_VERTICES) ? MAX_VERTICES : POLY_SIZE_RST;

    pbpc_state_t                  state_reg;
    pbpc_state_t                  state_next;
    logic                         keep_reg;
    logic                         keep_next;
    logic [CNT_W-1:0]             poly_n_reg;
    logic [CNT_W-1:0]             poly_n_next;
    pbpc_token_t                  tok0_reg;
    pbpc_token_t                  tok0_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         vtx_we;
    logic                         load_pt;
    logic                         out_load;
    pbpc_chk_t                    chk;

    logic signed [COORD_BITS-1:0] pt_x_reg;
    logic signed [COORD_BITS-1:0] pt_y_reg;
    logic signed [COORD_BITS-1:0] pt_z_reg;
    logic [INTEN_W-1:0]           pt_i_reg;
    logic signed [COORD_BITS-1:0] kept_x_reg;
    logic signed [COORD_BITS-1:0] kept_y_reg;
    logic signed [COORD_BITS-1:0] kept_z_reg;
    logic [INTEN_W-1:0]           kept_i_reg;

    // Token chain: tok[i] enters cell i, tok[MAX_VERTICES] leaves the last cell.
    pbpc_token_t                  tok [MAX_VERTICES+1];
    logic signed [COORD_BITS-1:0] vx  [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vy  [MAX_VERTICES];

    // Box and band checks look at the point as it is offered at the input.
    pbpc_bounds #(
        .COORD_BITS (COORD_BITS)
    ) u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pt_x      (pos_x),
        .pt_y      (pos_y),
        .pt_z      (pos_z),
        .chk       (chk)
    );

    assign tok[0] = tok0_reg;

    // One cell per vertex slot. Each cell owns its vertex and tests the edge
    // to its right-hand neighbor; the last physical cell wraps to vertex 0.
    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        logic signed [COORD_BITS-1:0] nx;
        logic signed [COORD_BITS-1:0] ny;

        if (i == MAX_VERTICES - 1)
        begin : g_wrap
            assign nx = vx[0];
            assign ny = vy[0];
        end
        else
        begin : g_next
            assign nx = vx[i+1];
            assign ny = vy[i+1];
        end

        pbpc_edge_cell #(
            .IDX          (i),
            .MAX_VERTICES (MAX_VERTICES),
            .COORD_BITS   (COORD_BITS),
            .CNT_W        (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vtx_we   (vtx_we),
            .vtx_slot (table_arg),
            .wr_x     (pos_x),
            .wr_y     (pos_y),
            .pt_x     (pt_x_reg),
            .pt_y     (pt_y_reg),
            .v0_x     (vx[0]),
            .v0_y     (vy[0]),
            .nxt_x    (nx),
            .nxt_y    (ny),
            .poly_n   (poly_n_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .vx       (vx[i]),
            .vy       (vy[i])
        );
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Control: table actions take effect at the transfer; a point either
    // drops at once, goes straight to the output, or starts a chain walk.
    always_comb
    begin
        state_next  = state_reg;
        keep_next   = keep_reg;
        poly_n_next = poly_n_reg;
        tok0_next   = '0;
        vtx_we      = 1'b0;
        load_pt     = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_POINT:
                        begin
                            load_pt = 1'b1;
                            if (finite && chk.box_ok)
                            begin
                                if (chk.band_ok && (poly_n_reg >= CNT_W'(MIN_POLY)))
                                begin
                                    tok0_next.valid = 1'b1;
                                    state_next      = ST_WALK;
                                end
                                else
                                begin
                                    keep_next  = 1'b1;
                                    state_next = ST_DONE;
                                end
                            end
                        end
                        ACT_VERTEX:
                        begin
                            // Slots at or above MAX_VERTICES match no cell.
                            vtx_we = 1'b1;
                        end
                        ACT_SIZE:
                        begin
                            if (32'(table_arg) > MAX_VERTICES)
                            begin
                                poly_n_next = CNT_W'(MAX_VERTICES);
                            end
                            else
                            begin
                                poly_n_next = CNT_W'(table_arg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Odd crossing count means the point sits inside the footprint.
                if (tok[MAX_VERTICES].valid)
                begin
                    keep_next  = !tok[MAX_VERTICES].parity;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!keep_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keep_reg      <= 1'b0;
            poly_n_reg    <= CNT_W'(SIZE_RST);
            tok0_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keep_reg      <= keep_next;
            poly_n_reg    <= poly_n_next;
            tok0_reg      <= tok0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Point hold registers and the output register carry payload only.
    always_ff @(posedge clk)
    begin
        if (load_pt)
        begin
            pt_x_reg <= pos_x;
            pt_y_reg <= pos_y;
            pt_z_reg <= pos_z;
            pt_i_reg <= intensity;
        end
        if (out_load)
        begin
            kept_x_reg <= pt_x_reg;
            kept_y_reg <= pt_y_reg;
            kept_z_reg <= pt_z_reg;
            kept_i_reg <= pt_i_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kept_x         = kept_x_reg;
    assign kept_y         = kept_y_reg;
    assign kept_z         = kept_z_reg;
    assign kept_intensity = kept_i_reg;

    // The chain is empty whenever the block takes input.
    a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !tok[MAX_VERTICES].valid)
        else $error("token left the chain while the block was idle");

    // A token only enters the chain right after an accepted point.
    a_token_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tok0_reg.valid |-> ($past(in_valid && in_ready) && (state_reg == ST_WALK)))
        else $error("token injected without an accepted point");

    // A new result only comes from the done state with a keep decision.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg == ST_DONE) && $past(keep_reg)))
        else $error("result raised outside the done state");

    // The polygon size never exceeds the number of cells.
    a_size_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        poly_n_reg <= CNT_W'(MAX_VERTICES))
        else $error("polygon size beyond the cell count");

endmodule

`default_nettype wire
